>>> hw/rtl/touch_slider_to_stick_mapper_assert.svh
// assertion helpers for the touch slider mapper
`ifndef TOUCH_SLIDER_TO_STICK_MAPPER_ASSERT_SVH
`define TOUCH_SLIDER_TO_STICK_MAPPER_ASSERT_SVH

// condition that must hold at every clock edge outside reset
`define TSSM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define TSSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tssm_pkg.sv
package tssm_pkg;

  localparam int unsigned ChipW   = 12;
  localparam int unsigned AxisW   = 8;
  localparam int unsigned VecW    = 32;
  localparam int unsigned ZoneW   = 16;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [4:0]       ZoneNoTouch  = 5'd16;
  localparam logic             ArcadeReset  = 1'b1;
  localparam logic [AxisW-1:0] CenterReset  = 8'd128;
  localparam logic [AxisW-1:0] AxisMin      = 8'd0;
  localparam logic [AxisW-1:0] AxisMax      = 8'd255;

  // register index, taken from paddr bit 2
  localparam logic RegArcadeMode  = 1'b0;
  localparam logic RegStickCenter = 1'b1;

  typedef struct packed {
    logic [3:0]       hi;
    logic [4:0]       lo;
    logic [AxisW-1:0] value;
  } zone_t;

  typedef struct packed {
    logic [AxisW-1:0] right_y;
    logic [AxisW-1:0] right_x;
    logic [AxisW-1:0] left_y;
    logic [AxisW-1:0] left_x;
    logic [VecW-1:0]  vec;
  } result_t;

  // one scan of a zone: returns the new zone state, whose value is the axis output
  function automatic zone_t zone_update(zone_t z, logic [ZoneW-1:0] bits,
                                        logic [AxisW-1:0] center);
    zone_t      n;
    logic [3:0] hi;
    logic [3:0] lo;
    logic       left;
    logic       right;
    hi = 4'd0;
    lo = 4'd0;
    for (int i = 0; i < ZoneW; i++) begin
      if (bits[i]) hi = 4'(i);
    end
    for (int i = ZoneW - 1; i >= 0; i--) begin
      if (bits[i]) lo = 4'(i);
    end
    left  = (hi > z.hi && {1'b0, lo} >= z.lo) || (hi >= z.hi && {1'b0, lo} > z.lo);
    right = (hi < z.hi && {1'b0, lo} <= z.lo) || (hi <= z.hi && {1'b0, lo} < z.lo);
    if (bits == '0) begin
      n.hi    = 4'd0;
      n.lo    = ZoneNoTouch;
      n.value = center;
    end else begin
      n.hi = hi;
      n.lo = {1'b0, lo};
      if (left) begin
        n.value = AxisMin;
      end else if (right) begin
        n.value = AxisMax;
      end else begin
        n.value = z.value;
      end
    end
    return n;
  endfunction

endpackage

>>> hw/rtl/touch_slider_to_stick_mapper.sv
// each input transfer's result is registered into the output register (or the skid register)
// throughput: one item per cycle while the skid register is empty; a two-entry output stage
// (result register plus skid register) lets the input take an item while a stalled result waits
// reset (rst_ni low, asynchronous): arcade mode on, stick center 128, both zones untouched
// with held value 128, output and skid stages empty
`include "touch_slider_to_stick_mapper_assert.svh"

module touch_slider_to_stick_mapper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // apb-style configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tssm_pkg::AddrW-1:0]    paddr,
  input  logic [tssm_pkg::DataW-1:0]    pwdata,
  output logic [tssm_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  // scan input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tssm_pkg::ChipW-1:0]    chip0_touch_i,
  input  logic [tssm_pkg::ChipW-1:0]    chip1_touch_i,
  input  logic [tssm_pkg::ChipW-1:0]    chip2_touch_i,
  input  logic [tssm_pkg::ChipW-1:0]    chip3_touch_i,
  // axis output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tssm_pkg::AxisW-1:0]    right_y_axis_o,
  output logic [tssm_pkg::AxisW-1:0]    right_x_axis_o,
  output logic [tssm_pkg::AxisW-1:0]    left_y_axis_o,
  output logic [tssm_pkg::AxisW-1:0]    left_x_axis_o,
  output logic [tssm_pkg::VecW-1:0]     touch_vector_o
);

  // configuration registers
  logic                       arcade_q;
  logic [tssm_pkg::AxisW-1:0] center_q;
  logic                       cfg_wr;

  // zone tracking state: upper zone is vector bits 31..16, lower zone 15..0
  tssm_pkg::zone_t upper_q, upper_d;
  tssm_pkg::zone_t lower_q, lower_d;

  // output register and skid register
  tssm_pkg::result_t res;
  tssm_pkg::result_t out_q, out_d;
  tssm_pkg::result_t skid_q, skid_d;
  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;

  logic                      in_xfer;
  logic                      out_xfer;
  logic [tssm_pkg::VecW-1:0] vec;

  // ---------------------------------------------------------------------------
  // configuration port: zero-wait writes, register picked by paddr bit 2
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arcade_q <= tssm_pkg::ArcadeReset;
      center_q <= tssm_pkg::CenterReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        tssm_pkg::RegArcadeMode:  arcade_q <= pwdata[0];
        tssm_pkg::RegStickCenter: center_q <= pwdata[tssm_pkg::AxisW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tssm_pkg::RegArcadeMode:  prdata = {{(tssm_pkg::DataW-1){1'b0}}, arcade_q};
      tssm_pkg::RegStickCenter: prdata = {{(tssm_pkg::DataW-tssm_pkg::AxisW){1'b0}}, center_q};
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshakes: input is held off only while the skid register is occupied
  // ---------------------------------------------------------------------------
  assign in_stall_o  = skid_valid_q;
  assign in_xfer     = in_valid_i & ~skid_valid_q;
  assign out_xfer    = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // result logic, straight from the input ports
  // ---------------------------------------------------------------------------
  // electrodes 4..11 of each chip, chip0 in the top byte
  assign vec = {chip0_touch_i[11:4], chip1_touch_i[11:4],
                chip2_touch_i[11:4], chip3_touch_i[11:4]};

  assign upper_d = tssm_pkg::zone_update(upper_q, vec[31:16], center_q);
  assign lower_d = tssm_pkg::zone_update(lower_q, vec[15:0], center_q);

  always_comb begin
    res.vec = vec;
    if (arcade_q) begin
      // each byte drives one axis, XORed with the center value
      res.right_y = vec[31:24] ^ center_q;
      res.right_x = vec[23:16] ^ center_q;
      res.left_y  = vec[15:8] ^ center_q;
      res.left_x  = vec[7:0] ^ center_q;
    end else begin
      // slide mode: x from zone motion, y parked at center
      res.right_y = center_q;
      res.right_x = lower_d.value;
      res.left_y  = center_q;
      res.left_x  = upper_d.value;
    end
  end

  // zone state only moves on a slide-mode transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= '{hi: 4'd0, lo: tssm_pkg::ZoneNoTouch, value: tssm_pkg::CenterReset};
      lower_q <= '{hi: 4'd0, lo: tssm_pkg::ZoneNoTouch, value: tssm_pkg::CenterReset};
    end else if (in_xfer && !arcade_q) begin
      upper_q <= upper_d;
      lower_q <= lower_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: results go to the output register, or to the skid register
  // when the output register holds a result that is not leaving this cycle
  // ---------------------------------------------------------------------------
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_xfer) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (in_xfer) begin
      if (!out_valid_q || out_xfer) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign right_y_axis_o = out_q.right_y;
  assign right_x_axis_o = out_q.right_x;
  assign left_y_axis_o  = out_q.left_y;
  assign left_x_axis_o  = out_q.left_x;
  assign touch_vector_o = out_q.vec;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `TSSM_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_q || out_valid_q,
                      "skid register full while output register empty")
  `TSSM_ASSERT_ALWAYS(a_upper_no_touch, upper_q.lo != tssm_pkg::ZoneNoTouch || upper_q.hi == 4'd0,
                      "upper zone marked untouched with a nonzero high bit")
  `TSSM_ASSERT_NEXT(a_arcade_keeps_zones, in_xfer && arcade_q,
                    $stable(upper_q) && $stable(lower_q),
                    "zone state changed on an arcade-mode transfer")
  `TSSM_ASSERT_NEXT(a_untouched_lower, in_xfer && !arcade_q && vec[15:0] == 16'd0,
                    lower_q.lo == tssm_pkg::ZoneNoTouch && out_valid_q,
                    "untouched lower zone not recorded")

endmodule

>>> dv/touch_slider_to_stick_mapper_tb.sv
`timescale 1ns / 1ps

module touch_slider_to_stick_mapper_tb;

  // one scan as it enters the block: the four raw chip words
  typedef struct packed {
    logic [tssm_pkg::ChipW-1:0] c0;
    logic [tssm_pkg::ChipW-1:0] c1;
    logic [tssm_pkg::ChipW-1:0] c2;
    logic [tssm_pkg::ChipW-1:0] c3;
  } scan_t;

  // cycles without any transfer before the run is declared hung
  localparam int QuietLimit = 5000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;

  // configuration port, driven only by the sequencing block
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [tssm_pkg::AddrW-1:0]   paddr = '0;
  logic [tssm_pkg::DataW-1:0]   pwdata = '0;
  logic [tssm_pkg::DataW-1:0]   prdata;
  logic                         pready;

  // scan input side
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [tssm_pkg::ChipW-1:0]   chip0_touch_i = '0;
  logic [tssm_pkg::ChipW-1:0]   chip1_touch_i = '0;
  logic [tssm_pkg::ChipW-1:0]   chip2_touch_i = '0;
  logic [tssm_pkg::ChipW-1:0]   chip3_touch_i = '0;

  // axis output side
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [tssm_pkg::AxisW-1:0]   right_y_axis_o;
  logic [tssm_pkg::AxisW-1:0]   right_x_axis_o;
  logic [tssm_pkg::AxisW-1:0]   left_y_axis_o;
  logic [tssm_pkg::AxisW-1:0]   left_x_axis_o;
  logic [tssm_pkg::VecW-1:0]    touch_vector_o;

  // scans waiting for the driver, and axis results the block still owes us
  scan_t                        scan_q[$];
  tssm_pkg::result_t            axis_expect_q[$];

  // mirror of the block's registers and slide state
  logic                         arcade_cfg = tssm_pkg::ArcadeReset;
  logic [tssm_pkg::AxisW-1:0]   center_cfg = tssm_pkg::CenterReset;
  tssm_pkg::zone_t              upper_zone = '{4'd0, tssm_pkg::ZoneNoTouch, tssm_pkg::CenterReset};
  tssm_pkg::zone_t              lower_zone = '{4'd0, tssm_pkg::ZoneNoTouch, tssm_pkg::CenterReset};

  // finger model for the slide stimulus, one per zone (0 upper, 1 lower)
  int                           finger_pos[2] = '{7, 7};
  int                           finger_wid[2] = '{2, 2};

  int                           gap_pct = 0;    // chance the sender idles in a cycle
  int                           stall_pct = 0;  // chance the receiver stalls in a cycle
  int                           err_cnt = 0;
  int                           quiet_cycles = 0;
  logic                         scan_taken = 1'b0;
  tssm_pkg::result_t            axis_want;

  touch_slider_to_stick_mapper u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .chip0_touch_i  (chip0_touch_i),
    .chip1_touch_i  (chip1_touch_i),
    .chip2_touch_i  (chip2_touch_i),
    .chip3_touch_i  (chip3_touch_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .right_y_axis_o (right_y_axis_o),
    .right_x_axis_o (right_x_axis_o),
    .left_y_axis_o  (left_y_axis_o),
    .left_x_axis_o  (left_x_axis_o),
    .touch_vector_o (touch_vector_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // one zone scan: find the outermost touched electrodes and compare them with
  // the ones recorded from the previous scan
  function automatic tssm_pkg::zone_t zone_next(tssm_pkg::zone_t z, logic [15:0] bits,
                                                logic [tssm_pkg::AxisW-1:0] center);
    tssm_pkg::zone_t n;
    logic [4:0]      top;
    logic [4:0]      bottom;
    logic            slid_left;
    logic            slid_right;
    top    = 5'd0;
    bottom = tssm_pkg::ZoneNoTouch;
    for (int i = 0; i < 16; i++) begin
      if (bits[i]) top = 5'(i);
    end
    for (int i = 15; i >= 0; i--) begin
      if (bits[i]) bottom = 5'(i);
    end
    if (bits == 16'h0000) begin
      // finger lifted: forget the position, stick back to rest
      n.hi    = 4'd0;
      n.lo    = tssm_pkg::ZoneNoTouch;
      n.value = center;
    end else begin
      slid_left  = (top > {1'b0, z.hi} && bottom >= z.lo) ||
                   (top >= {1'b0, z.hi} && bottom > z.lo);
      slid_right = (top < {1'b0, z.hi} && bottom <= z.lo) ||
                   (top <= {1'b0, z.hi} && bottom < z.lo);
      n.hi = top[3:0];
      n.lo = bottom;
      if (slid_left) begin
        n.value = tssm_pkg::AxisMin;
      end else if (slid_right) begin
        n.value = tssm_pkg::AxisMax;
      end else begin
        n.value = z.value;  // touched but not moved, or spread both ways
      end
    end
    return n;
  endfunction

  // axes for one accepted scan; advances the zone mirror in stick mode only
  function automatic tssm_pkg::result_t map_scan(scan_t s);
    tssm_pkg::result_t r;
    logic [31:0]       v;
    v     = {s.c0[11:4], s.c1[11:4], s.c2[11:4], s.c3[11:4]};
    r.vec = v;
    if (arcade_cfg) begin
      r.right_y = v[31:24] ^ center_cfg;
      r.right_x = v[23:16] ^ center_cfg;
      r.left_y  = v[15:8] ^ center_cfg;
      r.left_x  = v[7:0] ^ center_cfg;
    end else begin
      upper_zone = zone_next(upper_zone, v[31:16], center_cfg);
      lower_zone = zone_next(lower_zone, v[15:0], center_cfg);
      r.right_y  = center_cfg;
      r.right_x  = lower_zone.value;
      r.left_y   = center_cfg;
      r.left_x   = upper_zone.value;
    end
    return r;
  endfunction

  // spread a touch vector back over the chip words, with junk in the unused nibbles
  function automatic scan_t pack_scan(logic [31:0] v);
    scan_t s;
    s.c0 = {v[31:24], 4'($urandom())};
    s.c1 = {v[23:16], 4'($urandom())};
    s.c2 = {v[15:8], 4'($urandom())};
    s.c3 = {v[7:0], 4'($urandom())};
    return s;
  endfunction

  function automatic void check_axis(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: new scans go out at the falling edge once the last one transferred
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || scan_taken) begin
      if (scan_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        {chip0_touch_i, chip1_touch_i, chip2_touch_i, chip3_touch_i} <= scan_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: output transfers are checked before this edge's input is predicted,
  // since a result leaving now always belongs to an older scan
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    scan_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (axis_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual vec %0h", $time,
                   touch_vector_o);
          err_cnt++;
        end else begin
          axis_want = axis_expect_q.pop_front();
          check_axis("right_y_axis", 32'(axis_want.right_y), 32'(right_y_axis_o));
          check_axis("right_x_axis", 32'(axis_want.right_x), 32'(right_x_axis_o));
          check_axis("left_y_axis", 32'(axis_want.left_y), 32'(left_y_axis_o));
          check_axis("left_x_axis", 32'(axis_want.left_x), 32'(left_x_axis_o));
          check_axis("touch_vector", axis_want.vec, touch_vector_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        axis_expect_q.push_back(map_scan({chip0_touch_i, chip1_touch_i,
                                          chip2_touch_i, chip3_touch_i}));
      end
    end
  end

  // watchdog: any transfer on either channel or the config port counts as progress
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing
  // ---------------------------------------------------------------------------

  // hold the sender until every queued scan has gone and every result came back
  task automatic settle();
    do begin
      @(posedge clk_i);
      #1;
    end while (scan_q.size() != 0 || in_valid_i || axis_expect_q.size() != 0);
  endtask

  // write one register (junk above its width), then read it back
  task automatic set_reg(logic idx, logic [tssm_pkg::AxisW-1:0] value);
    logic [31:0] mask;
    logic [31:0] readback;
    mask = (idx == tssm_pkg::RegStickCenter) ? 32'h0000_00FF : 32'h0000_0001;
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = ($urandom() & ~mask) | (32'(value) & mask);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == tssm_pkg::RegStickCenter) begin
      center_cfg = value;
    end else begin
      arcade_cfg = value[0];
    end
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    if ((readback & mask) !== (32'(value) & mask)) begin
      $display("%0t: register %0d readback mismatch, expected %0h, actual %0h", $time, idx,
               32'(value) & mask, readback & mask);
      err_cnt++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // mostly fingers sliding over each zone, with lifts and some noise mixed in
  task automatic push_slides(int n);
    logic [15:0] zone_bits[2];
    logic [47:0] raw;
    int          r;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 20) begin
        raw = {$urandom(), 16'($urandom())};
        scan_q.push_back(raw);
      end else begin
        for (int z = 0; z < 2; z++) begin
          r = $urandom_range(99);
          if (r < 12) begin
            zone_bits[z] = 16'h0000;
          end else if (r < 20) begin
            zone_bits[z] = 16'($urandom());
          end else begin
            finger_pos[z] = finger_pos[z] + int'($urandom_range(2)) - 1;
            if (finger_pos[z] < 0) finger_pos[z] = 0;
            if (finger_pos[z] > 15) finger_pos[z] = 15;
            if ($urandom_range(9) == 0) finger_wid[z] = $urandom_range(4, 1);
            zone_bits[z] = 16'h0000;
            for (int i = 0; i < finger_wid[z]; i++) begin
              if (finger_pos[z] + i < 16) zone_bits[z][finger_pos[z] + i] = 1'b1;
            end
          end
        end
        scan_q.push_back(pack_scan({zone_bits[0], zone_bits[1]}));
      end
    end
  endtask

  initial begin
    // reset once, inputs idle throughout
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // sender idles rarely, receiver stalls heavily
    gap_pct   = 6;
    stall_pct = 80;

    // arcade mapping with the reset configuration: extremes and unused chip bits
    scan_q.push_back('{12'h000, 12'h000, 12'h000, 12'h000});
    scan_q.push_back('{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
    scan_q.push_back('{12'h00F, 12'h00F, 12'h00F, 12'h00F});
    scan_q.push_back('{12'hFF0, 12'hFF0, 12'hFF0, 12'hFF0});
    scan_q.push_back('{12'hA5A, 12'h5A5, 12'hA5A, 12'h5A5});
    scan_q.push_back('{12'h010, 12'h020, 12'h400, 12'h800});
    settle();

    // stick mode, each zone walked through its slide cases
    set_reg(tssm_pkg::RegArcadeMode, 8'd0);
    scan_q.push_back(pack_scan({16'h0000, 16'h0000}));  // both untouched
    scan_q.push_back(pack_scan({16'h0020, 16'h0001}));  // first touch: held / moved right
    scan_q.push_back(pack_scan({16'h0040, 16'h0002}));  // moved left in both zones
    scan_q.push_back(pack_scan({16'h0010, 16'h0001}));  // moved right in both zones
    scan_q.push_back(pack_scan({16'h0010, 16'h0001}));  // touched, not moved
    scan_q.push_back(pack_scan({16'h0038, 16'h8001}));  // spread both ways / moved left
    scan_q.push_back(pack_scan({16'h8000, 16'hFFFF}));  // top electrode / full zone
    scan_q.push_back(pack_scan({16'h0001, 16'h0000}));  // bottom electrode / lift
    push_slides(300);
    settle();

    set_reg(tssm_pkg::RegStickCenter, 8'd0);
    push_slides(250);
    settle();

    // now the sender idles a lot and the receiver rarely stalls
    gap_pct   = 80;
    stall_pct = 6;
    set_reg(tssm_pkg::RegArcadeMode, 8'd1);
    set_reg(tssm_pkg::RegStickCenter, 8'd255);
    push_slides(200);
    settle();

    set_reg(tssm_pkg::RegArcadeMode, 8'd0);
    push_slides(250);
    settle();

    // back to back, no idling on either side
    gap_pct   = 0;
    stall_pct = 0;
    set_reg(tssm_pkg::RegArcadeMode, 8'd1);
    set_reg(tssm_pkg::RegStickCenter, 8'd0);
    push_slides(150);
    settle();

    set_reg(tssm_pkg::RegArcadeMode, 8'd0);
    set_reg(tssm_pkg::RegStickCenter, 8'($urandom_range(255)));
    push_slides(150);
    settle();

    // idle clocking at the end catches any stray result
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && axis_expect_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
